// ===== src/ptce_pkg.sv =====
// ============================================================================
// ptce_pkg - shared types and constants
// Types, codes and digit geometry shared by the victim selector modules.
// ============================================================================
package ptce_pkg;

  localparam int SLOT_W  = 6;
  localparam int STAMP_W = 32;
  localparam int MODE_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // stamps are compared MSB-first, one digit per cycle
  localparam int DIGIT_W     = 16;
  localparam int NUM_DIGITS  = STAMP_W / DIGIT_W;
  localparam int DIGIT_CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVICT = 1'b1;

  // policy_mode codes
  localparam logic [MODE_W-1:0] MODE_DROP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LRU  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QOS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_QOS;

  // register word index (paddr[2])
  localparam logic REG_POLICY = 1'b0;

  // candidate class selection for a scan
  typedef enum logic [1:0] {
    SEL_ANY   = 2'd0,  // any valid entry
    SEL_RU    = 2'd1,  // regular unreliable only
    SEL_RU_RR = 2'd2   // regular unreliable first, then regular reliable
  } sel_t;

  typedef struct packed {
    logic               valid;
    logic               expedited;
    logic               reliable;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // sequencer -> comparator control
  typedef struct packed {
    logic init;   // start of an eviction: forget previous best
    logic step;   // one digit of the current candidate
    logic first;  // most significant digit, candidate word on read data
    logic last;   // least significant digit, decision commits
  } cmp_ctrl_t;

endpackage

// ===== src/pending_table_class_eviction.sv =====
// ============================================================================
// pending_table_class_eviction - class-aware victim selector
// Pending-request table with oldest-entry eviction under a class policy.
// ============================================================================
// Sequencing: a write transaction completes while the block stays idle;
//   an eviction with a scan passes ST_SCAN then ST_FIN, a dropped one ST_FIN.
// Throughput: one transaction at a time; the scan reads the slots in turn
//   from the table memory through a 16-bit digit comparator.
// Reset: synchronous; a clearing pass zeroes the table (in_stall high
//   meanwhile); policy_mode resets to class-aware.
module pending_table_class_eviction #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [ptce_pkg::SLOT_W-1:0]    slot,
  input  logic                           entry_valid,
  input  logic                           class_expedited,
  input  logic                           class_reliable,
  input  logic [ptce_pkg::STAMP_W-1:0]   use_stamp,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           evicted,
  output logic [ptce_pkg::SLOT_W-1:0]    victim_slot,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptce_pkg::PADDR_W-1:0]   paddr,
  input  logic [ptce_pkg::PDATA_W-1:0]   pwdata,
  output logic [ptce_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int SLOT_EXT_W = (IDX_W > ptce_pkg::SLOT_W) ? IDX_W : ptce_pkg::SLOT_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,   // post-reset sweep of the table
    ST_IDLE  = 4'b0010,   // waiting for a transaction
    ST_SCAN  = 4'b0100,   // walking the slots, one digit per cycle
    ST_FIN   = 4'b1000    // result out, victim invalidated
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [IDX_W-1:0]                 scan_idx;
  logic [ptce_pkg::DIGIT_CNT_W-1:0] digit_cnt;
  ptce_pkg::sel_t                   sel;
  logic [ptce_pkg::MODE_W-1:0]      policy_mode;

  logic                             in_accept;
  logic                             cfg_write;
  logic                             idx_last;
  logic                             digit_last;
  logic                             fin_load;
  logic                             evict_scan;
  ptce_pkg::sel_t                   sel_next;

  logic [SLOT_EXT_W-1:0]            slot_ext;
  logic                             slot_in_range;
  logic [SLOT_EXT_W-1:0]            victim_ext;

  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_addr;
  ptce_pkg::entry_t                 wr_data;
  logic [IDX_W-1:0]                 rd_addr;
  ptce_pkg::entry_t                 rd_data;

  ptce_pkg::cmp_ctrl_t              cmp_ctrl;
  logic                             found;
  logic [IDX_W-1:0]                 best_idx;

  // --------------------------------------------------------------------------
  // Configuration: single register, word index in paddr[2]
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == ptce_pkg::REG_POLICY)
                     ? ptce_pkg::PDATA_W'(policy_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= ptce_pkg::MODE_RESET;
    end else if (cfg_write && paddr[2] == ptce_pkg::REG_POLICY) begin
      policy_mode <= pwdata[ptce_pkg::MODE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Transaction decode
  // --------------------------------------------------------------------------
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign slot_ext      = SLOT_EXT_W'(slot);
  assign slot_in_range = {1'b0, slot_ext} < (SLOT_EXT_W + 1)'(TABLE_DEPTH);

  // Class policy: drop modes and a regular unreliable request skip the scan
  always_comb begin
    evict_scan = 1'b0;
    sel_next   = ptce_pkg::SEL_ANY;
    if (policy_mode == ptce_pkg::MODE_LRU) begin
      evict_scan = 1'b1;
    end else if (policy_mode == ptce_pkg::MODE_QOS) begin
      if (class_expedited) begin
        evict_scan = 1'b1;
        sel_next   = ptce_pkg::SEL_RU_RR;
      end else if (class_reliable) begin
        evict_scan = 1'b1;
        sel_next   = ptce_pkg::SEL_RU;
      end
    end
  end

  assign idx_last   = (scan_idx == IDX_W'(TABLE_DEPTH - 1));
  assign digit_last = (digit_cnt == ptce_pkg::DIGIT_CNT_W'(ptce_pkg::NUM_DIGITS - 1));
  assign fin_load   = (state == ST_FIN) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (idx_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_accept && action == ptce_pkg::ACT_EVICT) begin
          state_next = evict_scan ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN:  if (idx_last && digit_last) state_next = ST_FIN;
      ST_FIN:   if (fin_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_idx  <= '0;
      digit_cnt <= '0;
      sel       <= ptce_pkg::SEL_ANY;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        scan_idx <= idx_last ? '0 : scan_idx + 1'b1;
      end
      if (state == ST_SCAN) begin
        digit_cnt <= digit_last ? '0 : digit_cnt + 1'b1;
        if (digit_last) begin
          scan_idx <= idx_last ? '0 : scan_idx + 1'b1;
        end
      end
      if (in_accept && action == ptce_pkg::ACT_EVICT) begin
        sel <= sel_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Table access. One write port shared by the sweep, write transactions
  // and victim invalidation. Read address runs one slot ahead of the scan;
  // while idle it parks on slot 0 so the first candidate is ready at once.
  // --------------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan_idx;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (in_accept && action == ptce_pkg::ACT_WRITE) begin
      wr_en   = slot_in_range;
      wr_addr = slot_ext[IDX_W-1:0];
      wr_data = '{valid:     entry_valid,
                  expedited: class_expedited,
                  reliable:  class_reliable,
                  stamp:     use_stamp};
    end else if (fin_load && found) begin
      // only the valid bit matters once cleared
      wr_en   = 1'b1;
      wr_addr = best_idx;
    end
  end

  assign rd_addr = (state == ST_SCAN) ? scan_idx + 1'b1 : '0;

  ptce_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Oldest-entry tracker
  // --------------------------------------------------------------------------
  assign cmp_ctrl = '{init:  in_accept && action == ptce_pkg::ACT_EVICT,
                      step:  state == ST_SCAN,
                      first: digit_cnt == '0,
                      last:  digit_last};

  ptce_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cmp_ctrl),
    .sel      (sel),
    .cand     (rd_data),
    .cand_idx (scan_idx),
    .found    (found),
    .best_idx (best_idx)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign victim_ext = SLOT_EXT_W'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      evicted     <= found;
      victim_slot <= found ? victim_ext[ptce_pkg::SLOT_W-1:0] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !wr_en)
    else $error("table written during scan");

  a_drop_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (victim_slot == '0))
    else $error("dropped eviction reports a nonzero slot");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && out_stall) |=> (state == ST_FIN))
    else $error("left finish state while result still pending");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, scan_idx} < (IDX_W + 1)'(TABLE_DEPTH)))
    else $error("scan index beyond table depth");

  a_evict_valid_victim: assert property (@(posedge clk) disable iff (rst)
    (fin_load && found) |=> (out_valid && evicted))
    else $error("found victim not reported");

endmodule

// ===== src/ptce_table.sv =====
// ============================================================================
// ptce_table - slot storage
// One-write, one-read memory of table entries with registered read data.
// ============================================================================
module ptce_table #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  ptce_pkg::entry_t   wr_data,
  input  logic [IDX_W-1:0]   rd_addr,
  output ptce_pkg::entry_t   rd_data
);

  ptce_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/ptce_cmp.sv =====
// ============================================================================
// ptce_cmp - digit-serial oldest-entry tracker
// Rotates candidate and best stamps one digit per cycle, MSB first, and
// keeps the best class rank, stamp and slot seen so far.
// ============================================================================
module ptce_cmp #(
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  ptce_pkg::cmp_ctrl_t ctrl,
  input  ptce_pkg::sel_t      sel,
  input  ptce_pkg::entry_t    cand,
  input  logic [IDX_W-1:0]    cand_idx,
  output logic                found,
  output logic [IDX_W-1:0]    best_idx
);

  localparam int SW = ptce_pkg::STAMP_W;
  localparam int DW = ptce_pkg::DIGIT_W;

  logic [SW-1:0] cand_sr;
  logic [SW-1:0] best_sr;
  logic          best_prio;
  logic          decided;
  logic          take;
  // rank of the candidate must be held until its decision commits
  logic          cand_prio_q;

  logic          cand_match;
  logic          cand_prio;
  logic [DW-1:0] cand_dig;
  logic [DW-1:0] best_dig;
  logic [SW-1:0] cand_src;
  logic [SW-1:0] cand_rot;
  logic [SW-1:0] best_rot;
  logic          dec_now;
  logic          take_now;

  always_comb begin
    case (sel)
      ptce_pkg::SEL_ANY:   cand_match = cand.valid;
      ptce_pkg::SEL_RU:    cand_match = cand.valid && !cand.expedited && !cand.reliable;
      ptce_pkg::SEL_RU_RR: cand_match = cand.valid && !cand.expedited;
      default:             cand_match = 1'b0;
    endcase
    // unreliable outranks reliable when both classes qualify
    cand_prio = (sel == ptce_pkg::SEL_RU_RR) && !cand.reliable;
  end

  assign cand_src = ctrl.first ? cand.stamp : cand_sr;
  assign cand_dig = cand_src[SW-1 -: DW];
  assign best_dig = best_sr[SW-1 -: DW];
  assign cand_rot = {cand_src[SW-DW-1:0], cand_src[SW-1 -: DW]};
  assign best_rot = {best_sr[SW-DW-1:0], best_sr[SW-1 -: DW]};

  always_comb begin
    dec_now  = decided;
    take_now = take;
    if (ctrl.first) begin
      dec_now  = 1'b0;
      take_now = 1'b0;
      if (!cand_match) begin
        dec_now = 1'b1;
      end else if (!found || (cand_prio && !best_prio)) begin
        dec_now  = 1'b1;
        take_now = 1'b1;
      end else if (!cand_prio && best_prio) begin
        dec_now = 1'b1;
      end
    end
    if (!dec_now) begin
      if (cand_dig < best_dig) begin
        dec_now  = 1'b1;
        take_now = 1'b1;
      end else if (cand_dig > best_dig) begin
        dec_now = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      decided <= 1'b0;
      take    <= 1'b0;
    end else if (ctrl.init) begin
      found   <= 1'b0;
      decided <= 1'b0;
      take    <= 1'b0;
    end else if (ctrl.step) begin
      decided <= dec_now;
      take    <= take_now;
      if (ctrl.last && take_now) begin
        found <= 1'b1;
      end
    end
  end

  // payload: stamps rotate a digit per step, full word restored each slot
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      cand_sr <= cand_rot;
      if (ctrl.last && take_now) begin
        best_sr <= cand_rot;
      end else begin
        best_sr <= best_rot;
      end
      if (ctrl.first) begin
        cand_prio_q <= cand_prio;
      end
      if (ctrl.last && take_now) begin
        best_idx  <= cand_idx;
        best_prio <= ctrl.first ? cand_prio : cand_prio_q;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench - pending_table_class_eviction victim selector
// Drives table writes and eviction requests through the valid/stall input
// channel, programs policy_mode over the APB-style port, and checks every
// eviction result against an in-bench model of the table and the class
// policy or a result typed into the row. Directed rows come first, then
// random phases with different policies and idle patterns on both channels.
// ============================================================================
module testbench;

  localparam int DEPTH           = 64;
  localparam int SETTLE_CYCLES   = 8;     // lets a trailing write transaction finish
  localparam int HOLD_CYCLES     = 600;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles before giving up

  // unused policy code, behaves as drop
  localparam logic [ptce_pkg::MODE_W-1:0]  MODE_SPARE  = 2'd3;
  // register byte addresses: word index sits in paddr[2]
  localparam logic [ptce_pkg::PADDR_W-1:0] ADDR_POLICY = {ptce_pkg::REG_POLICY, 2'b00};
  localparam logic [ptce_pkg::PADDR_W-1:0] ADDR_SPARE  = {~ptce_pkg::REG_POLICY, 2'b00};

  // one input transaction
  typedef struct packed {
    logic                         action;
    logic [ptce_pkg::SLOT_W-1:0]  slot;
    logic                         entry_valid;
    logic                         class_expedited;
    logic                         class_reliable;
    logic [ptce_pkg::STAMP_W-1:0] use_stamp;
  } table_req_t;

  // one result transaction
  typedef struct packed {
    logic                        evicted;
    logic [ptce_pkg::SLOT_W-1:0] victim_slot;
  } evict_result_t;

  // directed rows: register writes, items checked by the predictor, and
  // items whose result is written into the row
  typedef enum logic [1:0] {ROW_CONFIG, ROW_ITEM, ROW_ITEM_TYPED} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    table_req_t                   req;
    logic [ptce_pkg::PADDR_W-1:0] addr;
    logic [ptce_pkg::PDATA_W-1:0] data;
    evict_result_t                typed;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic                          action;
  logic [ptce_pkg::SLOT_W-1:0]   slot;
  logic                          entry_valid;
  logic                          class_expedited;
  logic                          class_reliable;
  logic [ptce_pkg::STAMP_W-1:0]  use_stamp;
  logic                          out_valid;
  logic                          out_stall;
  logic                          evicted;
  logic [ptce_pkg::SLOT_W-1:0]   victim_slot;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ptce_pkg::PADDR_W-1:0]  paddr;
  logic [ptce_pkg::PDATA_W-1:0]  pwdata;
  logic [ptce_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  pending_table_class_eviction #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .slot(slot), .entry_valid(entry_valid),
    .class_expedited(class_expedited), .class_reliable(class_reliable),
    .use_stamp(use_stamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .evicted(evicted), .victim_slot(victim_slot),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // --------------------------------------------------------------------------
  // Table model: shadow copy of the slots and of policy_mode
  // --------------------------------------------------------------------------
  logic                         tbl_valid [DEPTH];
  logic                         tbl_exp   [DEPTH];
  logic                         tbl_rel   [DEPTH];
  logic [ptce_pkg::STAMP_W-1:0] tbl_stamp [DEPTH];
  logic [ptce_pkg::MODE_W-1:0]  policy_shadow;

  evict_result_t expected_evictions[$];
  dir_row_t      directed_rows[$];

  int send_gap_pct;      // chance per cycle that the sender idles
  int recv_gap_pct;      // chance per cycle that the receiver stalls
  bit hold_request;      // asks the receiver for a long hold-off
  int mismatches;
  int n_writes, n_evicts, n_victims, n_drops;

  function automatic bit chance(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // oldest valid slot of a class; any_class ignores the class bits,
  // otherwise only regular entries with the given reliable bit qualify.
  // Strict compare keeps the lowest slot on equal stamps.
  function automatic int oldest_entry(input bit any_class, input bit want_rel);
    int best;
    best = -1;
    for (int k = 0; k < DEPTH; k++) begin
      if (!tbl_valid[k]) continue;
      if (!any_class && (tbl_exp[k] || tbl_rel[k] != want_rel)) continue;
      if (best < 0 || tbl_stamp[k] < tbl_stamp[best]) best = k;
    end
    return best;
  endfunction

  // applies one accepted transaction to the model; returns 1 when it
  // produces a result (every eviction request does, writes never)
  function automatic bit apply_to_table(input table_req_t req,
                                        output evict_result_t res);
    int victim;
    victim = -1;
    res = '0;
    if (req.action == ptce_pkg::ACT_WRITE) begin
      tbl_valid[req.slot] = req.entry_valid;
      tbl_exp[req.slot]   = req.class_expedited;
      tbl_rel[req.slot]   = req.class_reliable;
      tbl_stamp[req.slot] = req.use_stamp;
      n_writes++;
      return 1'b0;
    end
    n_evicts++;
    case (policy_shadow)
      ptce_pkg::MODE_LRU: victim = oldest_entry(1'b1, 1'b0);
      ptce_pkg::MODE_QOS: begin
        // expedited requests fall back to regular reliable entries;
        // regular unreliable requests never evict
        if (req.class_expedited) begin
          victim = oldest_entry(1'b0, 1'b0);
          if (victim < 0) victim = oldest_entry(1'b0, 1'b1);
        end else if (req.class_reliable) begin
          victim = oldest_entry(1'b0, 1'b0);
        end
      end
      default: ;  // drop and the unused code never evict
    endcase
    if (victim >= 0) begin
      tbl_valid[victim] = 1'b0;
      res.evicted     = 1'b1;
      res.victim_slot = victim[ptce_pkg::SLOT_W-1:0];
      n_victims++;
    end else begin
      n_drops++;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void add_write(input int s, input bit v, input bit e,
                                    input bit r,
                                    input logic [ptce_pkg::STAMP_W-1:0] st);
    dir_row_t row;
    row = '{kind: ROW_ITEM, req: '0, addr: '0, data: '0, typed: '0};
    row.req = '{action: ptce_pkg::ACT_WRITE, slot: s[ptce_pkg::SLOT_W-1:0],
                entry_valid: v, class_expedited: e, class_reliable: r,
                use_stamp: st};
    directed_rows.push_back(row);
  endfunction

  // typed_ok: the result below is written into the row, otherwise the
  // predictor supplies it
  function automatic void add_evict(input bit e, input bit r, input bit typed_ok,
                                    input bit ev, input int vs);
    dir_row_t row;
    row = '{kind: ROW_ITEM, req: '0, addr: '0, data: '0, typed: '0};
    if (typed_ok) row.kind = ROW_ITEM_TYPED;
    row.req.action          = ptce_pkg::ACT_EVICT;
    row.req.class_expedited = e;
    row.req.class_reliable  = r;
    row.typed = '{evicted: ev, victim_slot: vs[ptce_pkg::SLOT_W-1:0]};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg_write(input logic [ptce_pkg::PADDR_W-1:0] a,
                                        input logic [ptce_pkg::PDATA_W-1:0] d);
    dir_row_t row;
    row = '{kind: ROW_CONFIG, req: '0, addr: a, data: d, typed: '0};
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: stalls at random, takes the long hold-off on request, and
  // checks each accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  initial begin
    evict_result_t want;
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_evictions.size() == 0) begin
          $error("result with nothing expected: evicted=%0b victim_slot=%0d",
                 evicted, victim_slot);
          mismatches++;
        end else begin
          want = expected_evictions.pop_front();
          if (evicted !== want.evicted) begin
            $error("evicted: expected %0b, got %0b", want.evicted, evicted);
            mismatches++;
          end
          if (victim_slot !== want.victim_slot) begin
            $error("victim_slot: expected %0d, got %0d",
                   want.victim_slot, victim_slot);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= chance(recv_gap_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run after too many cycles without any transaction
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (psel === 1'b1 && penable === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_evictions.size());
    $display("testbench: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender and register access tasks; all start right after a rising edge
  // --------------------------------------------------------------------------

  // offers one transaction, holds it until accepted, then updates the model.
  // in_valid is left high so back-to-back items need no extra assignment.
  task automatic send_item(input table_req_t req, input bit typed_ok,
                           input evict_result_t typed);
    evict_result_t predicted;
    while (chance(send_gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= req.action;
    slot            <= req.slot;
    entry_valid     <= req.entry_valid;
    class_expedited <= req.class_expedited;
    class_reliable  <= req.class_reliable;
    use_stamp       <= req.use_stamp;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (apply_to_table(req, predicted)) begin
      if (typed_ok) predicted = typed;
      expected_evictions.push_back(predicted);
    end
  endtask

  // stops offering, waits for every outstanding result, then lets a
  // trailing write transaction finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_evictions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_policy();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_POLICY;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== ptce_pkg::PDATA_W'(policy_shadow)) begin
      $error("policy_mode readback: expected %0d, got %0d", policy_shadow, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // setup + access write, then a readback of policy_mode
  task automatic write_reg(input logic [ptce_pkg::PADDR_W-1:0] addr,
                           input logic [ptce_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    // only word 0 exists; the upper data bits are dropped
    if (addr[ptce_pkg::PADDR_W-1:2] == ptce_pkg::REG_POLICY)
      policy_shadow = data[ptce_pkg::MODE_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    read_policy();
  endtask

  function automatic table_req_t random_req();
    table_req_t r;
    r.action          = chance(45) ? ptce_pkg::ACT_EVICT : ptce_pkg::ACT_WRITE;
    r.slot            = ptce_pkg::SLOT_W'($urandom_range(DEPTH - 1, 0));
    r.entry_valid     = chance(88);
    r.class_expedited = 1'($urandom_range(1, 0));
    r.class_reliable  = 1'($urandom_range(1, 0));
    // narrow stamp ranges make ties between slots common
    case ($urandom_range(3, 0))
      0:       r.use_stamp = ptce_pkg::STAMP_W'($urandom_range(7, 0));
      1:       r.use_stamp = 32'hFFFF_FFF8 | ptce_pkg::STAMP_W'($urandom_range(7, 0));
      default: r.use_stamp = $urandom;
    endcase
    return r;
  endfunction

  // one random phase: program the policy while idle, set the idle pattern,
  // optionally squeeze the block with a long receiver hold-off, then stream
  task automatic run_phase(input logic [ptce_pkg::MODE_W-1:0] mode, input int s_pct,
                           input int r_pct, input int count, input bit squeeze);
    table_req_t r;
    wait_idle();
    write_reg(ADDR_POLICY, ($urandom & ~32'h3) | ptce_pkg::PDATA_W'(mode));
    send_gap_pct = s_pct;
    recv_gap_pct = r_pct;
    if (squeeze) begin
      // receiver sits on the first result while evictions keep coming,
      // so the block has to stall its input
      hold_request = 1'b1;
      repeat (12) begin
        r = random_req();
        r.action = ptce_pkg::ACT_EVICT;
        send_item(r, 1'b0, '0);
      end
    end
    repeat (count) send_item(random_req(), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    action          = ptce_pkg::ACT_WRITE;
    slot            = '0;
    entry_valid     = 1'b0;
    class_expedited = 1'b0;
    class_reliable  = 1'b0;
    use_stamp       = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    hold_request    = 1'b0;
    send_gap_pct    = 25;
    recv_gap_pct    = 83;
    mismatches      = 0;
    n_writes = 0; n_evicts = 0; n_victims = 0; n_drops = 0;
    policy_shadow   = ptce_pkg::MODE_RESET;
    for (int k = 0; k < DEPTH; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_exp[k]   = 1'b0;
      tbl_rel[k]   = 1'b0;
      tbl_stamp[k] = '0;
    end

    // directed rows, class-aware policy out of reset
    add_evict(1, 1, 1, 0, 0);                  // empty table: nothing to evict
    add_write(0,  1, 0, 0, 32'hFFFF_FFFF);     // regular unreliable, newest
    add_write(63, 1, 0, 1, 32'h0000_0000);     // regular reliable, oldest
    add_write(5,  1, 1, 1, 32'h0000_0000);     // expedited, never a qos victim
    add_write(7,  1, 0, 0, 32'hFFFF_FFFF);     // ties with slot 0
    add_evict(0, 0, 1, 0, 0);                  // regular unreliable request drops
    add_evict(0, 1, 1, 1, 0);                  // tie goes to the lower slot
    add_evict(1, 0, 1, 1, 7);
    add_evict(1, 1, 1, 1, 63);                 // falls back to regular reliable
    add_evict(1, 0, 1, 0, 0);                  // only an expedited entry left
    add_write(5,  0, 1, 1, 32'h0000_0000);     // invalidate by write
    add_write(12, 1, 1, 0, 32'h8000_0000);
    add_write(33, 1, 0, 1, 32'h0000_0001);
    add_write(40, 1, 0, 0, 32'h0001_0000);     // differs only in the upper digit
    add_reg_write(ADDR_POLICY, ptce_pkg::PDATA_W'(ptce_pkg::MODE_LRU));
    add_evict(0, 0, 1, 1, 33);                 // any class, oldest wins
    add_evict(1, 1, 0, 0, 0);
    add_evict(0, 1, 0, 0, 0);
    add_evict(0, 0, 1, 0, 0);                  // table empty again
    add_write(1,  1, 0, 0, 32'h0000_0005);
    add_reg_write(ADDR_POLICY, ptce_pkg::PDATA_W'(ptce_pkg::MODE_DROP));
    add_evict(1, 1, 1, 0, 0);
    add_reg_write(ADDR_POLICY, ptce_pkg::PDATA_W'(MODE_SPARE));
    add_evict(1, 0, 1, 0, 0);                  // unused code drops as well
    add_reg_write(ADDR_SPARE, ptce_pkg::PDATA_W'(ptce_pkg::MODE_QOS));  // no such register
    add_evict(0, 1, 1, 0, 0);
    add_reg_write(ADDR_POLICY, 32'hFFFF_FFF6);      // upper bits ignored
    add_evict(0, 1, 1, 1, 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset keeps in_stall high
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    read_policy();
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: begin
          wait_idle();
          write_reg(directed_rows[i].addr, directed_rows[i].data);
        end
        ROW_ITEM:       send_item(directed_rows[i].req, 1'b0, '0);
        ROW_ITEM_TYPED: send_item(directed_rows[i].req, 1'b1, directed_rows[i].typed);
        default: ;
      endcase
    end

    // random traffic: slow sender / busy receiver, then the reverse, then
    // no idling at all (with the long hold-off), then the dropping codes
    run_phase(ptce_pkg::MODE_QOS,   25, 83, 550, 1'b0);
    run_phase(ptce_pkg::MODE_LRU,   83, 25, 450, 1'b0);
    run_phase(ptce_pkg::MODE_QOS,    0,  0, 388, 1'b1);
    run_phase(ptce_pkg::MODE_DROP,   0,  0, 100, 1'b0);
    run_phase(MODE_SPARE,            0,  0, 100, 1'b0);

    wait_idle();
    $display("summary: %0d table writes, %0d eviction requests (%0d victims, %0d drops)",
             n_writes, n_evicts, n_victims, n_drops);
    $display("summary: all four policy codes, unknown register, long result hold-off");
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ptce_pkg.sv
src/ptce_table.sv
src/ptce_cmp.sv
src/pending_table_class_eviction.sv
tb/testbench.sv
